/* design/bcidx_pkg.sv */
package bcidx_pkg;

    localparam int MAX_RANK   = 4;
    localparam int DIM_BITS   = 16;
    localparam int SHAPE_BITS = 64;
    localparam int POS_BITS   = 32;
    localparam int STRIDE_W   = 33;
    localparam int IDX_W      = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STAGES = MAX_RANK * DIM_BITS;

    localparam logic [STRIDE_W-1:0] STRIDE_MAX = {STRIDE_W{1'b1}};
    localparam logic [STRIDE_W-1:0] COUNT_MAX  = {1'b0, {POS_BITS{1'b1}}};
    localparam logic [SHAPE_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INCOMPAT = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_FIRST_RANK   = 2'd0,
        REG_SECOND_RANK  = 2'd1,
        REG_FIRST_SHAPE  = 2'd2,
        REG_SECOND_SHAPE = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                                busy;
        status_t                             status;
        logic [POS_BITS-1:0]                 count;
        logic [MAX_RANK-1:0][POS_BITS-1:0]   out_strides;
        logic [MAX_RANK-1:0][POS_BITS-1:0]   first_strides;
        logic [MAX_RANK-1:0][POS_BITS-1:0]   second_strides;
        logic [MAX_RANK-1:0]                 first_keep;
        logic [MAX_RANK-1:0]                 second_keep;
    } shape_t;

    typedef struct packed {
        status_t             status;
        logic [POS_BITS-1:0] pos;
    } item_t;

endpackage

/* design/bcidx_if.sv */
interface bcidx_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_position;

    modport source (output valid, output out_position, input ready);
    modport sink   (input valid, input out_position, output ready);
endinterface

interface bcidx_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] first_index;
    logic [31:0] second_index;
    logic [31:0] out_count;

    modport source (output valid, output status, output first_index,
                    output second_index, output out_count, input ready);
    modport sink   (input valid, input status, input first_index,
                    input second_index, input out_count, output ready);
endinterface

/* design/bcidx_shape.sv */
module bcidx_shape (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  bcidx_pkg::reg_index_t           cfg_index,
    input  logic [bcidx_pkg::SHAPE_BITS-1:0] cfg_data,
    output bcidx_pkg::shape_t               shape
);
    import bcidx_pkg::*;

    localparam int PROD_W = STRIDE_W + DIM_BITS;

    logic [2:0]            first_rank_reg, second_rank_reg;
    logic [SHAPE_BITS-1:0] first_shape_reg, second_shape_reg;
    logic                  busy_reg;
    logic [IDX_W-1:0]      step_reg;
    logic [STRIDE_W-1:0]   fs_acc_reg, ss_acc_reg, os_acc_reg;
    logic [STRIDE_W-1:0]   fs_acc_next, ss_acc_next, os_acc_next;
    logic [STRIDE_W-1:0]   first_strides_reg [MAX_RANK];
    logic [STRIDE_W-1:0]   second_strides_reg [MAX_RANK];
    logic [STRIDE_W-1:0]   out_strides_reg [MAX_RANK];

    logic [DIM_BITS-1:0] fd [MAX_RANK];
    logic [DIM_BITS-1:0] sd [MAX_RANK];
    logic [DIM_BITS-1:0] od [MAX_RANK];
    logic [PROD_W-1:0]   fp, sp, op;
    logic                compat, empty, ovf;

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_dim
        if ((k + 1) * DIM_BITS <= SHAPE_BITS) begin : g_in
            assign fd[k] = (k < int'(first_rank_reg))
                ? first_shape_reg[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
            assign sd[k] = (k < int'(second_rank_reg))
                ? second_shape_reg[k*DIM_BITS +: DIM_BITS] : DIM_BITS'(1);
        end else begin : g_out
            assign fd[k] = (k < int'(first_rank_reg)) ? '0 : DIM_BITS'(1);
            assign sd[k] = (k < int'(second_rank_reg)) ? '0 : DIM_BITS'(1);
        end
        assign od[k] = (fd[k] > sd[k]) ? fd[k] : sd[k];
        assign shape.out_strides[k]    = out_strides_reg[k][POS_BITS-1:0];
        assign shape.first_strides[k]  = first_strides_reg[k][POS_BITS-1:0];
        assign shape.second_strides[k] = second_strides_reg[k][POS_BITS-1:0];
        assign shape.first_keep[k]     = (fd[k] == od[k]);
        assign shape.second_keep[k]    = (sd[k] == od[k]);
    end

    always_comb
    begin
        compat = 1'b1;
        empty  = 1'b0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            if (fd[k] != sd[k] && fd[k] != DIM_BITS'(1) && sd[k] != DIM_BITS'(1))
                compat = 1'b0;
            if (fd[k] == '0 || sd[k] == '0)
                empty = 1'b1;
        end
        ovf = (os_acc_reg > COUNT_MAX);
        shape.busy = busy_reg;
        if (!compat)
        begin
            shape.status = ST_INCOMPAT;
            shape.count  = '0;
        end
        else if (empty)
        begin
            shape.status = ST_EMPTY;
            shape.count  = ovf ? '1 : os_acc_reg[POS_BITS-1:0];
        end
        else if (ovf)
        begin
            shape.status = ST_OVERFLOW;
            shape.count  = '1;
        end
        else
        begin
            shape.status = ST_OK;
            shape.count  = os_acc_reg[POS_BITS-1:0];
        end
    end

    always_comb
    begin
        fp = fs_acc_reg * fd[step_reg];
        sp = ss_acc_reg * sd[step_reg];
        op = os_acc_reg * od[step_reg];
        fs_acc_next = (fp > PROD_W'(STRIDE_MAX)) ? STRIDE_MAX : fp[STRIDE_W-1:0];
        ss_acc_next = (sp > PROD_W'(STRIDE_MAX)) ? STRIDE_MAX : sp[STRIDE_W-1:0];
        os_acc_next = (op > PROD_W'(STRIDE_MAX)) ? STRIDE_MAX : op[STRIDE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_rank_reg   <= '0;
            second_rank_reg  <= '0;
            first_shape_reg  <= SHAPE_RESET;
            second_shape_reg <= SHAPE_RESET;
            busy_reg         <= 1'b1;
            step_reg         <= '0;
            fs_acc_reg       <= STRIDE_W'(1);
            ss_acc_reg       <= STRIDE_W'(1);
            os_acc_reg       <= STRIDE_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FIRST_RANK:   first_rank_reg   <= cfg_data[2:0];
                REG_SECOND_RANK:  second_rank_reg  <= cfg_data[2:0];
                REG_FIRST_SHAPE:  first_shape_reg  <= cfg_data;
                REG_SECOND_SHAPE: second_shape_reg <= cfg_data;
                default:          ;
            endcase
            busy_reg   <= 1'b1;
            step_reg   <= '0;
            fs_acc_reg <= STRIDE_W'(1);
            ss_acc_reg <= STRIDE_W'(1);
            os_acc_reg <= STRIDE_W'(1);
        end
        else if (busy_reg)
        begin
            fs_acc_reg <= fs_acc_next;
            ss_acc_reg <= ss_acc_next;
            os_acc_reg <= os_acc_next;
            if (step_reg == IDX_W'(MAX_RANK - 1))
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_we)
        begin
            first_strides_reg[step_reg]  <= fs_acc_reg;
            second_strides_reg[step_reg] <= ss_acc_reg;
            out_strides_reg[step_reg]    <= os_acc_reg;
        end
    end

endmodule

/* design/bcidx_front.sv */
module bcidx_front (
    input  logic              clk,
    input  logic              rst_n,
    bcidx_req_if.sink         request,
    input  bcidx_pkg::shape_t shape,
    output bcidx_pkg::item_t  head,
    output logic              head_valid,
    input  logic              head_pop
);
    import bcidx_pkg::*;

    item_t             queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    item_t             entry;
    logic              push, pop;

    assign request.ready = !shape.busy && (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push          = request.valid && request.ready;
    assign head_valid    = (count_reg != '0);
    assign pop           = head_pop && head_valid;
    assign head          = queue_mem[rd_ptr_reg];

    always_comb
    begin
        entry.pos    = request.out_position;
        entry.status = shape.status;
        if (shape.status == ST_OK && request.out_position >= shape.count)
            entry.status = ST_RANGE;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

/* design/bcidx_back.sv */
module bcidx_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bcidx_pkg::shape_t shape,
    input  bcidx_pkg::item_t  head,
    input  logic              head_valid,
    output logic              head_pop,
    bcidx_rsp_if.source       result
);
    import bcidx_pkg::*;

    localparam int WIDE_W = POS_BITS + DIM_BITS;
    localparam int MUL_W  = POS_BITS + DIM_BITS;

    typedef logic [MAX_RANK-1:0][DIM_BITS-1:0] coord_t;

    logic                v_reg   [DIV_STAGES];
    status_t             st_reg  [DIV_STAGES];
    logic [POS_BITS-1:0] rem_reg [DIV_STAGES];
    coord_t              crd_reg [DIV_STAGES];

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [POS_BITS-1:0] m_first_reg  [MAX_RANK];
    logic [POS_BITS-1:0] m_second_reg [MAX_RANK];

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [POS_BITS-1:0] out_first_reg, out_second_reg;
    logic [POS_BITS-1:0] first_sum, second_sum;
    logic                adv;

    assign adv      = !out_valid_reg || result.ready;
    assign head_pop = adv;

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        localparam int K = MAX_RANK - 1 - j / DIM_BITS;
        localparam int B = DIM_BITS - 1 - j % DIM_BITS;
        logic                v_in;
        status_t             st_in;
        logic [POS_BITS-1:0] rem_in;
        coord_t              crd_in;
        coord_t              crd_out;
        logic [WIDE_W-1:0]   div_w;
        logic                take;

        if (j == 0) begin : g_first
            assign v_in   = head_valid;
            assign st_in  = head.status;
            assign rem_in = head.pos;
            assign crd_in = '0;
        end else begin : g_next
            assign v_in   = v_reg[j-1];
            assign st_in  = st_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign crd_in = crd_reg[j-1];
        end

        assign div_w = WIDE_W'(shape.out_strides[K]) << B;
        assign take  = (WIDE_W'(rem_in) >= div_w);

        always_comb
        begin
            crd_out       = crd_in;
            crd_out[K][B] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (adv)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[j]  <= st_in;
                rem_reg[j] <= take ? rem_in - div_w[POS_BITS-1:0] : rem_in;
                crd_reg[j] <= crd_out;
            end
        end
    end

    for (genvar k = 0; k < MAX_RANK; k++) begin : g_mul
        logic [MUL_W-1:0] fprod, sprod;
        assign fprod = crd_reg[DIV_STAGES-1][k] *
            (shape.first_keep[k] ? shape.first_strides[k] : '0);
        assign sprod = crd_reg[DIV_STAGES-1][k] *
            (shape.second_keep[k] ? shape.second_strides[k] : '0);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                m_first_reg[k]  <= fprod[POS_BITS-1:0];
                m_second_reg[k] <= sprod[POS_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        first_sum  = '0;
        second_sum = '0;
        for (int k = 0; k < MAX_RANK; k++)
        begin
            first_sum  = first_sum + m_first_reg[k];
            second_sum = second_sum + m_second_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg   <= v_reg[DIV_STAGES-1];
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_status_reg   <= st_reg[DIV_STAGES-1];
            out_status_reg <= m_status_reg;
            out_first_reg  <= (m_status_reg == ST_OK) ? first_sum : '0;
            out_second_reg <= (m_status_reg == ST_OK) ? second_sum : '0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.first_index  = out_first_reg;
    assign result.second_index = out_second_reg;
    assign result.out_count    = shape.count;

endmodule

/* design/broadcast_index_generator_core.sv */
// Broadcast gather-index generator.
// Configuration: cfg_we/cfg_index/cfg_data writes one of four registers
// (first_rank, second_rank, first_shape, second_shape). Each write starts a
// derivation pass (one dimension per cycle through the stride multipliers);
// request.ready is low during the pass.
// Channel request: one word per cycle, while request.ready is high, carries out_position.
// Channel result: one word per request with status, first_index,
// second_index and out_count, in request order.
// Throughput: one word per cycle sustained while result.ready is high and no derivation pass runs.
// Path: an accepted request passes the queue, then the 64-stage restoring
// coordinate divider (one quotient bit per stage), one multiply stage and
// one summing stage before result valid.
// Reset: registers return to ranks 0 and unit shapes; the derivation pass
// runs first, so request.ready rises only once that pass has finished.
// Stall: a held result freezes the whole back pipeline; a 2-word queue
// keeps taking requests until it fills, then request.ready drops.
module broadcast_index_generator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  bcidx_pkg::reg_index_t            cfg_index,
    input  logic [bcidx_pkg::SHAPE_BITS-1:0] cfg_data,
    bcidx_req_if.sink                        request,
    bcidx_rsp_if.source                      result
);
    import bcidx_pkg::*;

    shape_t shape;
    item_t  head;
    logic   head_valid;
    logic   head_pop;

    bcidx_shape u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .shape     (shape)
    );

    bcidx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .shape      (shape),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    bcidx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .shape      (shape),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .result     (result)
    );

endmodule

/* design/bcidx_checker.sv */
module bcidx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] first_index,
    input logic [31:0] second_index,
    input logic [31:0] out_count
);
    import bcidx_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_index)
            && $stable(second_index) && $stable(status))
        else $error("result word changed while stalled");

    a_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> first_index == '0 && second_index == '0)
        else $error("indices not cleared on error status");

    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> out_count != '0)
        else $error("ok word with empty output");

    a_incompat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INCOMPAT |-> out_count == '0)
        else $error("incompatible shapes with nonzero count");

endmodule

bind broadcast_index_generator_core bcidx_checker u_bcidx_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .status       (result.status),
    .first_index  (result.first_index),
    .second_index (result.second_index),
    .out_count    (result.out_count)
);
